>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the heap allocator; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define BTH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition never true outside reset
`define BTH_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> sv/bth_pkg.sv
// ----------------------------------------------------------------------------
// bth_pkg
// Shared types, constants and helpers of the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bth_pkg;

	// byte store size, a power of two; addresses wrap modulo this
	localparam int MEM_BYTES = 65536;
	localparam int AW        = $clog2(MEM_BYTES);

	localparam logic [15:0] REGION_SPLIT_RST = 16'd32768;
	localparam logic [15:0] STACK_LIMIT_RST  = 16'd61440;

	// tag geometry
	localparam logic [31:0] HDR_BYTES  = 32'd8;
	localparam logic [31:0] FTR_BYTES  = 32'd4;
	localparam logic [31:0] TAG_BYTES  = 32'd12;
	localparam logic [31:0] USED_MARK  = 32'd1;

	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_EXTEND = 2'd2,
		ACT_FORMAT = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RES_OK    = 2'd0,
		RES_NOFIT = 2'd1,
		RES_SEGV  = 2'd2
	} res_t;

	typedef enum logic {
		CFG_REGION_SPLIT = 1'b0,
		CFG_STACK_LIMIT  = 1'b1
	} cfg_idx_t;

	// datapath micro-operations
	typedef enum logic [5:0] {
		OP_NONE, OP_LOAD, OP_EMIT,
		OP_A_RDB, OP_A_RDU, OP_A_HIT, OP_A_STEP, OP_MARK,
		OP_S0, OP_S1, OP_S2, OP_S3, OP_S4, OP_S5,
		OP_F_CLR, OP_F_RDP, OP_F_PREV, OP_F_RDPU, OP_F_MP,
		OP_F_RDS, OP_F_NEXT, OP_F_RDNU, OP_F_MN,
		OP_M_RA, OP_M_RB, OP_M_NS, OP_M_W0, OP_M_W1,
		OP_E_RDS, OP_E_NEXT, OP_E_RDN, OP_E_RDNU, OP_E_MG,
		OP_FM0, OP_FM1, OP_FM2, OP_FM3, OP_FM4, OP_FM5
	} op_t;

	typedef enum logic [5:0] {
		S_IDLE, S_DONE,
		S_A_CHK, S_A_RDB, S_A_RDU, S_A_DEC, S_MARK,
		S_S0, S_S1, S_S2, S_S3, S_S4, S_S5,
		S_F_CLR, S_F_RDP, S_F_PREV, S_F_RDPU, S_F_DEC1,
		S_F_RDS, S_F_NEXT, S_F_CHKN, S_F_RDNU, S_F_DEC2,
		S_M_RA, S_M_RB, S_M_NS, S_M_W0, S_M_W1,
		S_E_RDS, S_E_NEXT, S_E_CHK, S_E_RDN, S_E_RDNU, S_E_DEC, S_E_MG,
		S_FM0, S_FM1, S_FM2, S_FM3, S_FM4, S_FM5
	} state_t;

	// datapath to controller
	typedef struct packed {
		logic    mem_done;
		action_t in_action;
		action_t act;
		logic    walk_end;
		logic    fit;
		logic    need_split;
		logic    addr_gt8;
		logic    prev_ok;
		logic    next_lt_sl;
		logic    next_ok;
		logic    next_lt_rs;
		logic    ext_ok;
		logic    out_free;
	} dp_stat_t;

	function automatic logic op_is_mem(op_t op);
		logic r;
		case (op)
			OP_A_RDB, OP_A_RDU, OP_MARK,
			OP_S0, OP_S1, OP_S2, OP_S3, OP_S4, OP_S5,
			OP_F_CLR, OP_F_RDP, OP_F_RDPU, OP_F_RDS, OP_F_RDNU,
			OP_M_RA, OP_M_RB, OP_M_W0, OP_M_W1,
			OP_E_RDS, OP_E_RDN, OP_E_RDNU,
			OP_FM0, OP_FM1, OP_FM2, OP_FM3, OP_FM4, OP_FM5: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/bth_chan_if.sv
// ----------------------------------------------------------------------------
// bth_chan_if
// Request and response channels of the heap allocator, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bth_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] request_size;
	logic [15:0] block_address;
	logic [15:0] search_start;

	modport source (output valid, action, request_size, block_address, search_start,
		input ready);
	modport sink (input valid, action, request_size, block_address, search_start,
		output ready);
endinterface

interface bth_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] result_address;

	modport source (output valid, status, result_address, input ready);
	modport sink (input valid, status, result_address, output ready);
endinterface

`default_nettype wire

>>> sv/bth_mem.sv
// ----------------------------------------------------------------------------
// bth_mem
// Byte store with a 32-bit little-endian word access sequencer, one byte/cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bth_mem (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  we,
	input  wire logic [bth_pkg::AW-1:0] addr,
	input  wire logic [31:0]           wdata,
	output logic                       done,
	output logic [31:0]                rdata
);
	import bth_pkg::*;

	logic [7:0]    mem [MEM_BYTES];
	logic          busy_q, we_q, pend_q;
	logic [1:0]    k_q, rk_q;
	logic [AW-1:0] a_q;
	logic [31:0]   wd_q, rb_q;
	logic [7:0]    rbyte_q;
	logic [AW-1:0] baddr;
	logic          accept;

	assign accept = start && !busy_q && !pend_q;
	assign baddr  = a_q + AW'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			we_q   <= 1'b0;
			pend_q <= 1'b0;
			k_q    <= 2'd0;
			rk_q   <= 2'd0;
		end else begin
			pend_q <= busy_q && !we_q;
			rk_q   <= k_q;
			if (accept) begin
				busy_q <= 1'b1;
				we_q   <= we;
				k_q    <= 2'd0;
			end else if (busy_q) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q  <= addr;
			wd_q <= wdata;
		end
		if (pend_q)
			rb_q[8*rk_q +: 8] <= rbyte_q;
	end

	always_ff @(posedge clk) begin
		if (busy_q && we_q)
			mem[baddr] <= wd_q[8*k_q +: 8];
		rbyte_q <= mem[baddr];
	end

	assign done  = (busy_q && we_q && k_q == 2'd3) || (pend_q && rk_q == 2'd3);
	assign rdata = {rbyte_q, rb_q[23:0]};

endmodule

`default_nettype wire

>>> sv/bth_dp.sv
// ----------------------------------------------------------------------------
// bth_dp
// Allocator datapath: item, tag and config registers, address math, store.
// ----------------------------------------------------------------------------
`default_nettype none

module bth_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bth_pkg::op_t      op,
	output bth_pkg::dp_stat_t      stat,
	input  wire logic [1:0]        in_action,
	input  wire logic [15:0]       in_size,
	input  wire logic [15:0]       in_addr,
	input  wire logic [15:0]       in_start,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             out_status,
	output logic [15:0]            out_addr,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [15:0]       cfg_wdata
);
	import bth_pkg::*;

	logic [15:0] rs_q, sl_q;
	action_t     act_q;
	logic [15:0] size_q, addr_q, start_q;
	logic [33:0] i_q;
	logic [31:0] bsz_q, t_q, x_q, ns_q, prev_q, next_q, hdr_q, ma_q, mb_q;
	logic        merged_q;
	res_t        res_q;
	logic [15:0] result_q;
	logic        out_valid_q;
	res_t        out_res_q;
	logic [15:0] out_addr_q;

	logic [31:0] size_w, addr_w, rs_w, sl_w, self_w, h_w, rest_w;
	logic [31:0] m_addr, m_wdata;
	logic        m_we, m_done;
	logic [31:0] m_rdata;

	assign size_w = {16'd0, size_q};
	assign addr_w = {16'd0, addr_q};
	assign rs_w   = {16'd0, rs_q};
	assign sl_w   = {16'd0, sl_q};
	assign self_w = addr_w - HDR_BYTES;
	assign h_w    = i_q[31:0];
	assign rest_w = bsz_q - size_w - TAG_BYTES;

	function automatic logic same_region(logic [31:0] a, logic [31:0] b, logic [31:0] rs);
		return (a < rs) == (b < rs);
	endfunction

	// word address and write data per operation
	always_comb begin
		m_addr  = 32'd0;
		m_wdata = 32'd0;
		m_we    = 1'b0;
		case (op)
			OP_A_RDB:  m_addr = h_w;
			OP_A_RDU:  m_addr = h_w + FTR_BYTES;
			OP_MARK:   begin m_addr = hdr_q + FTR_BYTES; m_wdata = USED_MARK; m_we = 1'b1; end
			OP_S0:     begin m_addr = hdr_q; m_wdata = size_w; m_we = 1'b1; end
			OP_S1:     begin m_addr = hdr_q + FTR_BYTES; m_wdata = USED_MARK; m_we = 1'b1; end
			OP_S2:     begin m_addr = hdr_q + HDR_BYTES + size_w; m_wdata = size_w; m_we = 1'b1; end
			OP_S3:     begin m_addr = hdr_q + TAG_BYTES + size_w; m_wdata = rest_w; m_we = 1'b1; end
			OP_S4:     begin m_addr = hdr_q + TAG_BYTES + FTR_BYTES + size_w; m_we = 1'b1; end
			OP_S5:     begin m_addr = hdr_q + HDR_BYTES + bsz_q; m_wdata = rest_w; m_we = 1'b1; end
			OP_F_CLR:  begin m_addr = addr_w - FTR_BYTES; m_we = 1'b1; end
			OP_F_RDP:  m_addr = addr_w - TAG_BYTES;
			OP_F_RDPU: m_addr = prev_q + FTR_BYTES;
			OP_F_RDS:  m_addr = self_w;
			OP_F_RDNU: m_addr = next_q + FTR_BYTES;
			OP_M_RA:   m_addr = ma_q;
			OP_M_RB:   m_addr = mb_q;
			OP_M_W0:   begin m_addr = ma_q; m_wdata = ns_q; m_we = 1'b1; end
			OP_M_W1:   begin m_addr = ma_q + HDR_BYTES + ns_q; m_wdata = ns_q; m_we = 1'b1; end
			OP_E_RDS:  m_addr = self_w;
			OP_E_RDN:  m_addr = next_q;
			OP_E_RDNU: m_addr = next_q + FTR_BYTES;
			OP_FM0:    begin m_addr = 32'd0; m_wdata = rs_w - TAG_BYTES; m_we = 1'b1; end
			OP_FM1:    begin m_addr = FTR_BYTES; m_we = 1'b1; end
			OP_FM2:    begin m_addr = rs_w - FTR_BYTES; m_wdata = rs_w - TAG_BYTES; m_we = 1'b1; end
			OP_FM3:    begin m_addr = rs_w; m_wdata = sl_w - rs_w - TAG_BYTES; m_we = 1'b1; end
			OP_FM4:    begin m_addr = rs_w + FTR_BYTES; m_we = 1'b1; end
			OP_FM5:    begin
				m_addr  = sl_w - FTR_BYTES;
				m_wdata = sl_w - rs_w - TAG_BYTES;
				m_we    = 1'b1;
			end
			default:   m_addr = 32'd0;
		endcase
	end

	bth_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (op_is_mem(op)),
		.we     (m_we),
		.addr   (m_addr[AW-1:0]),
		.wdata  (m_wdata),
		.done   (m_done),
		.rdata  (m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q <= REGION_SPLIT_RST;
			sl_q <= STACK_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_REGION_SPLIT: rs_q <= cfg_wdata;
				CFG_STACK_LIMIT:  sl_q <= cfg_wdata;
				default:          rs_q <= rs_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (op == OP_EMIT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				act_q    <= action_t'(in_action);
				size_q   <= in_size;
				addr_q   <= in_addr;
				start_q  <= in_start;
				i_q      <= 34'd0;
				merged_q <= 1'b0;
				result_q <= 16'd0;
				res_q    <= (action_t'(in_action) == ACT_ALLOC) ? RES_NOFIT : RES_OK;
			end
			OP_EMIT: begin
				out_res_q  <= res_q;
				out_addr_q <= result_q;
			end
			OP_A_HIT: begin
				hdr_q    <= h_w;
				res_q    <= RES_OK;
				result_q <= 16'(h_w + HDR_BYTES);
			end
			OP_A_STEP: i_q  <= i_q + {2'b00, bsz_q} + 34'(TAG_BYTES);
			OP_F_PREV: prev_q <= addr_w - TAG_BYTES - HDR_BYTES - t_q;
			OP_F_MP:   begin ma_q <= prev_q; mb_q <= self_w; merged_q <= 1'b1; end
			OP_F_NEXT: next_q <= t_q + addr_w + FTR_BYTES;
			OP_F_MN:   begin ma_q <= merged_q ? prev_q : self_w; mb_q <= next_q; end
			OP_M_NS:   ns_q <= x_q + t_q + TAG_BYTES;
			OP_E_NEXT: begin
				next_q <= t_q + addr_w + FTR_BYTES;
				hdr_q  <= t_q + addr_w + FTR_BYTES;
				res_q  <= RES_SEGV;
			end
			OP_E_MG:   begin ma_q <= self_w; mb_q <= next_q; res_q <= RES_OK; end
			default:   ;
		endcase
		if (m_done) begin
			case (op)
				OP_A_RDB, OP_E_RDN: bsz_q <= m_rdata;
				OP_M_RA:            x_q   <= m_rdata;
				default:            t_q   <= m_rdata;
			endcase
		end
	end

	always_comb begin
		stat.mem_done   = m_done;
		stat.in_action  = action_t'(in_action);
		stat.act        = act_q;
		stat.walk_end   = i_q >= {18'd0, sl_q};
		stat.fit        = (t_q == 32'd0) && (bsz_q >= size_w) && (h_w >= {16'd0, start_q});
		stat.need_split = bsz_q > (size_w + TAG_BYTES);
		stat.addr_gt8   = addr_w > HDR_BYTES;
		stat.prev_ok    = (t_q == 32'd0) && same_region(self_w, prev_q, rs_w);
		stat.next_lt_sl = next_q < sl_w;
		stat.next_ok    = (t_q == 32'd0) && same_region(self_w, next_q, rs_w);
		stat.next_lt_rs = next_q < rs_w;
		stat.ext_ok     = (t_q == 32'd0) && (bsz_q >= size_w);
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_res_q;
	assign out_addr   = out_addr_q;

endmodule

`default_nettype wire

>>> sv/bth_ctrl.sv
// ----------------------------------------------------------------------------
// bth_ctrl
// Allocator sequencer: steps each action through datapath micro-operations.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bth_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bth_pkg::dp_stat_t stat,
	output bth_pkg::op_t           op
);
	import bth_pkg::*;

	state_t state_q, state_d;
	logic   m2_q;   // merge with the next block of a free is under way

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m2_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE)
				m2_q <= 1'b0;
			else if (state_q == S_F_DEC2 && stat.next_ok)
				m2_q <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (stat.in_action)
						ACT_ALLOC:  state_d = S_A_CHK;
						ACT_FREE:   state_d = S_F_CLR;
						ACT_EXTEND: state_d = S_E_RDS;
						default:    state_d = S_FM0;
					endcase
				end
			end
			S_A_CHK:  state_d = stat.walk_end ? S_DONE : S_A_RDB;
			S_A_RDB:  if (stat.mem_done) state_d = S_A_RDU;
			S_A_RDU:  if (stat.mem_done) state_d = S_A_DEC;
			S_A_DEC: begin
				if (stat.fit)
					state_d = stat.need_split ? S_S0 : S_MARK;
				else
					state_d = S_A_CHK;
			end
			S_MARK:   if (stat.mem_done) state_d = S_DONE;
			S_S0:     if (stat.mem_done) state_d = S_S1;
			S_S1:     if (stat.mem_done) state_d = S_S2;
			S_S2:     if (stat.mem_done) state_d = S_S3;
			S_S3:     if (stat.mem_done) state_d = S_S4;
			S_S4:     if (stat.mem_done) state_d = S_S5;
			S_S5: begin
				if (stat.mem_done)
					state_d = (stat.act == ACT_EXTEND) ? S_E_MG : S_DONE;
			end
			S_F_CLR:  if (stat.mem_done) state_d = stat.addr_gt8 ? S_F_RDP : S_F_RDS;
			S_F_RDP:  if (stat.mem_done) state_d = S_F_PREV;
			S_F_PREV: state_d = S_F_RDPU;
			S_F_RDPU: if (stat.mem_done) state_d = S_F_DEC1;
			S_F_DEC1: state_d = stat.prev_ok ? S_M_RA : S_F_RDS;
			S_F_RDS:  if (stat.mem_done) state_d = S_F_NEXT;
			S_F_NEXT: state_d = S_F_CHKN;
			S_F_CHKN: state_d = stat.next_lt_sl ? S_F_RDNU : S_DONE;
			S_F_RDNU: if (stat.mem_done) state_d = S_F_DEC2;
			S_F_DEC2: state_d = stat.next_ok ? S_M_RA : S_DONE;
			S_M_RA:   if (stat.mem_done) state_d = S_M_RB;
			S_M_RB:   if (stat.mem_done) state_d = S_M_NS;
			S_M_NS:   state_d = S_M_W0;
			S_M_W0:   if (stat.mem_done) state_d = S_M_W1;
			S_M_W1: begin
				if (stat.mem_done)
					state_d = (stat.act == ACT_FREE && !m2_q) ? S_F_RDS : S_DONE;
			end
			S_E_RDS:  if (stat.mem_done) state_d = S_E_NEXT;
			S_E_NEXT: state_d = S_E_CHK;
			S_E_CHK:  state_d = stat.next_lt_rs ? S_E_RDN : S_DONE;
			S_E_RDN:  if (stat.mem_done) state_d = S_E_RDNU;
			S_E_RDNU: if (stat.mem_done) state_d = S_E_DEC;
			S_E_DEC: begin
				if (stat.ext_ok)
					state_d = stat.need_split ? S_S0 : S_E_MG;
				else
					state_d = S_DONE;
			end
			S_E_MG:   state_d = S_M_RA;
			S_FM0:    if (stat.mem_done) state_d = S_FM1;
			S_FM1:    if (stat.mem_done) state_d = S_FM2;
			S_FM2:    if (stat.mem_done) state_d = S_FM3;
			S_FM3:    if (stat.mem_done) state_d = S_FM4;
			S_FM4:    if (stat.mem_done) state_d = S_FM5;
			S_FM5:    if (stat.mem_done) state_d = S_DONE;
			S_DONE:   if (stat.out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					op = OP_LOAD;
			end
			S_A_RDB:  op = OP_A_RDB;
			S_A_RDU:  op = OP_A_RDU;
			S_A_DEC:  op = stat.fit ? OP_A_HIT : OP_A_STEP;
			S_MARK:   op = OP_MARK;
			S_S0:     op = OP_S0;
			S_S1:     op = OP_S1;
			S_S2:     op = OP_S2;
			S_S3:     op = OP_S3;
			S_S4:     op = OP_S4;
			S_S5:     op = OP_S5;
			S_F_CLR:  op = OP_F_CLR;
			S_F_RDP:  op = OP_F_RDP;
			S_F_PREV: op = OP_F_PREV;
			S_F_RDPU: op = OP_F_RDPU;
			S_F_DEC1: if (stat.prev_ok) op = OP_F_MP;
			S_F_RDS:  op = OP_F_RDS;
			S_F_NEXT: op = OP_F_NEXT;
			S_F_RDNU: op = OP_F_RDNU;
			S_F_DEC2: if (stat.next_ok) op = OP_F_MN;
			S_M_RA:   op = OP_M_RA;
			S_M_RB:   op = OP_M_RB;
			S_M_NS:   op = OP_M_NS;
			S_M_W0:   op = OP_M_W0;
			S_M_W1:   op = OP_M_W1;
			S_E_RDS:  op = OP_E_RDS;
			S_E_NEXT: op = OP_E_NEXT;
			S_E_RDN:  op = OP_E_RDN;
			S_E_RDNU: op = OP_E_RDNU;
			S_E_MG:   op = OP_E_MG;
			S_FM0:    op = OP_FM0;
			S_FM1:    op = OP_FM1;
			S_FM2:    op = OP_FM2;
			S_FM3:    op = OP_FM3;
			S_FM4:    op = OP_FM4;
			S_FM5:    op = OP_FM5;
			S_DONE:   if (stat.out_free) op = OP_EMIT;
			default:  op = OP_NONE;
		endcase
	end

	`BTH_ASSERT(a_leave_idle, (state_q == S_IDLE && in_valid) |=> (state_q != S_IDLE), "item taken but sequencer stayed idle")
	`BTH_ASSERT(a_done_in_mem, stat.mem_done |-> op_is_mem(op), "word access finished outside a memory step")
	`BTH_ASSERT(a_emit_free, (state_q == S_DONE && stat.out_free) |=> (state_q == S_IDLE), "result slot free but item not retired")

endmodule

`default_nettype wire

>>> sv/boundary_tag_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_top
// First-fit boundary-tag heap manager over a private byte store.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch carries one request item (action, request_size, block_address,
//  search_start); out_ch returns exactly one item (status, result_address)
//  for each request, in order. Both are valid/ready.
//  cfg_we/cfg_index/cfg_wdata write region_split (0) or stack_limit (1);
//  write them only while no request is in flight.
//  The store is one byte wide, so every 32-bit tag read and write goes
//  through it a byte at a time. Allocate reads two tag words per block
//  walked, then marks the block or splits it. Free can do two merges;
//  extend can merge in the next block.
//  One request is worked on at a time; the next is taken once the previous
//  result sits in the output register, even if out_ch is stalled.
//  Reset restores the two config registers and clears all control state;
//  the heap content stays undefined until a format request lays it out.
//  A stalled receiver holds the result; the block then finishes the next
//  request and waits for the output register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_tag_heap_allocator_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bth_in_if.sink     in_ch,
	bth_out_if.source  out_ch,
	input  wire logic  cfg_we,
	input  wire logic  cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	import bth_pkg::*;

	op_t      op;
	dp_stat_t stat;

	// sequencer: owns the request handshake
	bth_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.op       (op)
	);

	// datapath: registers, tag math, byte store, result register
	bth_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.stat       (stat),
		.in_action  (in_ch.action),
		.in_size    (in_ch.request_size),
		.in_addr    (in_ch.block_address),
		.in_start   (in_ch.search_start),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_status (out_ch.status),
		.out_addr   (out_ch.result_address),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

endmodule

`default_nettype wire
